// File: hw/rtl/pem_pkg.sv
package pem_pkg;

    // Sizes of the shape table.
    localparam int MAX_SHAPES = 8;
    localparam int ENV_SIZE   = 256;
    localparam int SHAPE_W    = 3;
    localparam int POS_W      = 8;
    localparam int ADDR_W     = SHAPE_W + POS_W;
    localparam int SMP_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int CNT_W      = 4;
    localparam int REQ_W      = 2;

    // Ghost peak and stretch quotient are Q8.16.
    localparam int G_W        = 24;
    localparam int M_W        = 16;

    // Divider: two quotient bits per pipeline stage.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = G_W / DIV_BITS;

    localparam logic [POS_W-1:0] ENV_LAST = POS_W'(ENV_SIZE - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SHAPES);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WR_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_PEAK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd2;

endpackage

// File: hw/rtl/pem_if.sv
// Request channel: load items and queries.
interface pem_req_if import pem_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [SHAPE_W-1:0]   shape_index;
    logic [POS_W-1:0]     position;
    logic [SMP_W-1:0]     sample_value;
    logic [POS_W-1:0]     peak_value;
    logic [FRAC_W-1:0]    blend_fraction;

    modport source (output valid, req_type, shape_index, position, sample_value,
                    peak_value, blend_fraction, input ready);
    modport sink   (input valid, req_type, shape_index, position, sample_value,
                    peak_value, blend_fraction, output ready);
endinterface

// Result channel: one morphed sample per query.
interface pem_res_if import pem_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SMP_W-1:0]     morphed_sample;
    logic [POS_W-1:0]     out_position;
    logic                 range_error;

    modport source (output valid, morphed_sample, out_position, range_error,
                    input ready);
    modport sink   (input valid, morphed_sample, out_position, range_error,
                    output ready);
endinterface

// File: hw/rtl/peak_aligned_envelope_morph.sv
// Channel   Port         Direction  Carries
// request   i_req        in         load sample, load peak, query
// result    o_res        out        morphed sample, position, range error
// config    i_cfg_we/..  in         shape count
//
// One item enters per cycle unless the result register is blocked. The
// depth is set by the twelve-stage stretch divider plus the
// peak and sample RAM reads and the interpolation multipliers.
// Reset clears every stage valid bit, the peak valid bits and sets the shape
// count to one. The sample table is not cleared. When the result register is
// full and not taken, the whole pipeline holds; nothing is lost or repeated.
module peak_aligned_envelope_morph import pem_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    pem_req_if.sink          i_req,
    pem_res_if.source        o_res
);

    localparam int NSTG = 21;

    typedef struct packed {
        logic               vld;
        logic [REQ_W-1:0]   req;
        logic [SHAPE_W-1:0] idx;
        logic [SHAPE_W-1:0] nxt;
        logic [POS_W-1:0]   pos;
        logic [SMP_W-1:0]   smp;
        logic [POS_W-1:0]   pkv;
        logic [FRAC_W-1:0]  frac;
        logic               err;
        logic               left;
        logic [POS_W-1:0]   lim_a;
        logic [POS_W-1:0]   lim_b;
    } t_ctl;

    typedef struct packed {
        logic [ADDR_W-1:0] a0;
        logic [ADDR_W-1:0] a1;
        logic [FRAC_W-1:0] t;
    } t_fetch;

    // Source index, interpolation weight and read addresses for one shape.
    function automatic t_fetch calc_fetch(input logic [G_W-1:0] q,
                                          input logic [POS_W-1:0] lim,
                                          input logic left,
                                          input logic [SHAPE_W-1:0] shp);
        t_fetch r;
        logic [POS_W-1:0] x0;
        logic [POS_W-1:0] x1;
        logic [FRAC_W-1:0] t;
        x0 = q[G_W-1:FRAC_W];
        t  = q[FRAC_W-1:0];
        if (x0 > lim) begin
            x0 = lim;
            t  = '0;
        end
        x1 = (x0 == lim) ? lim : POS_W'(x0 + 1'b1);
        if (left) begin
            r.a0 = {shp, x0};
            r.a1 = {shp, x1};
        end else begin
            r.a0 = {shp, POS_W'(ENV_LAST - x0)};
            r.a1 = {shp, POS_W'(ENV_LAST - x1)};
        end
        r.t = t;
        return r;
    endfunction

    logic             en;
    logic [CNT_W-1:0] r_shape_count;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] nxt_wide;
    t_ctl             r_ctl [NSTG];
    t_ctl             n_ctl [NSTG];

    // Whole pipeline advances unless the result register is blocked.
    assign en          = !(o_res.valid && !o_res.ready);
    assign i_req.ready = en;

    // Shape count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_shape_count <= i_cfg_wdata;
        end
    end

    assign cnt      = (r_shape_count > MAX_CNT) ? MAX_CNT : r_shape_count;
    assign nxt_wide = CNT_W'({1'b0, i_req.shape_index} + 1'b1);

    // Peak store with valid bits, read at shape A and shape B.
    logic [MAX_SHAPES-1:0] r_pk_vld;
    logic                  r_pva;
    logic                  r_pvb;
    logic [POS_W-1:0]      pk_rd_a;
    logic [POS_W-1:0]      pk_rd_b;
    logic                  pk_we;

    assign pk_we = en && r_ctl[0].vld && (r_ctl[0].req == REQ_WR_PEAK);

    pem_ram #(.WIDTH(POS_W), .DEPTH(MAX_SHAPES)) u_peak_ram (
        .i_clk     (i_clk),
        .i_we      (pk_we),
        .i_waddr   (r_ctl[0].idx),
        .i_wdata   (r_ctl[0].pkv),
        .i_re      (en),
        .i_raddr_a (r_ctl[0].idx),
        .i_raddr_b (r_ctl[0].nxt),
        .o_rdata_a (pk_rd_a),
        .o_rdata_b (pk_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_vld <= '0;
        end else if (pk_we) begin
            r_pk_vld[r_ctl[0].idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pva <= r_pk_vld[r_ctl[0].idx];
            r_pvb <= r_pk_vld[r_ctl[0].nxt];
        end
    end

    // Stage 1: ghost peak G = pa*(1-f) + pb*f in Q8.16.
    logic [POS_W-1:0] pa;
    logic [POS_W-1:0] pb;
    logic [G_W:0]     g_sum;
    logic [G_W-1:0]   r_g;
    logic [POS_W-1:0] r_pa;
    logic [POS_W-1:0] r_pb;

    assign pa    = r_pva ? pk_rd_a : '0;
    assign pb    = r_pvb ? pk_rd_b : '0;
    assign g_sum = (G_W+1)'(pa * (17'h10000 - {1'b0, r_ctl[1].frac}))
                 + (G_W+1)'(pb * {1'b0, r_ctl[1].frac});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g  <= g_sum[G_W-1:0];
            r_pa <= pa;
            r_pb <= pb;
        end
    end

    // Stage 2: pick the section and form numerators and divisor.
    logic             left;
    logic [G_W-1:0]   d_raw;
    logic [POS_W-1:0] lim_a;
    logic [POS_W-1:0] lim_b;
    logic [POS_W-1:0] qpos;
    logic [M_W-1:0]   m_a;
    logic [M_W-1:0]   m_b;
    logic [M_W-1:0]   r_dm_a;
    logic [M_W-1:0]   r_dm_b;
    logic [G_W-1:0]   r_dd;

    assign left  = r_ctl[2].pos <= r_g[G_W-1:FRAC_W];
    assign d_raw = left ? r_g : G_W'({ENV_LAST, (G_W-POS_W)'(0)} - r_g);
    assign lim_a = left ? r_pa : POS_W'(ENV_LAST - r_pa);
    assign lim_b = left ? r_pb : POS_W'(ENV_LAST - r_pb);
    assign qpos  = left ? r_ctl[2].pos : POS_W'(ENV_LAST - r_ctl[2].pos);
    assign m_a   = M_W'(qpos * lim_a);
    assign m_b   = M_W'(qpos * lim_b);

    // A zero divisor means a ratio of zero: divide zero by one instead.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (d_raw == '0) begin
                r_dm_a <= '0;
                r_dm_b <= '0;
                r_dd   <= G_W'(1);
            end else begin
                r_dm_a <= m_a;
                r_dm_b <= m_b;
                r_dd   <= d_raw;
            end
        end
    end

    // Stages 3 to 14: stretch quotients for both shapes.
    logic [G_W-1:0] q_a;
    logic [G_W-1:0] q_b;

    pem_div u_div_a (
        .i_clk (i_clk),
        .i_en  (en),
        .i_m   (r_dm_a),
        .i_d   (r_dd),
        .o_q   (q_a)
    );

    pem_div u_div_b (
        .i_clk (i_clk),
        .i_en  (en),
        .i_m   (r_dm_b),
        .i_d   (r_dd),
        .o_q   (q_b)
    );

    // Stage 15: sample addresses, and sample loads in order with queries.
    t_fetch           fa;
    t_fetch           fb;
    logic             smp_we;
    logic [SMP_W-1:0] y0_a;
    logic [SMP_W-1:0] y1_a;
    logic [SMP_W-1:0] y0_b;
    logic [SMP_W-1:0] y1_b;
    logic [FRAC_W-1:0] r_t_a;
    logic [FRAC_W-1:0] r_t_b;

    assign fa = calc_fetch(q_a, r_ctl[15].lim_a, r_ctl[15].left, r_ctl[15].idx);
    assign fb = calc_fetch(q_b, r_ctl[15].lim_b, r_ctl[15].left, r_ctl[15].nxt);
    assign smp_we = en && r_ctl[15].vld && (r_ctl[15].req == REQ_WR_SAMPLE);

    pem_ram #(.WIDTH(SMP_W), .DEPTH(MAX_SHAPES*ENV_SIZE)) u_shape_ram_a (
        .i_clk     (i_clk),
        .i_we      (smp_we),
        .i_waddr   ({r_ctl[15].idx, r_ctl[15].pos}),
        .i_wdata   (r_ctl[15].smp),
        .i_re      (en),
        .i_raddr_a (fa.a0),
        .i_raddr_b (fa.a1),
        .o_rdata_a (y0_a),
        .o_rdata_b (y1_a)
    );

    pem_ram #(.WIDTH(SMP_W), .DEPTH(MAX_SHAPES*ENV_SIZE)) u_shape_ram_b (
        .i_clk     (i_clk),
        .i_we      (smp_we),
        .i_waddr   ({r_ctl[15].idx, r_ctl[15].pos}),
        .i_wdata   (r_ctl[15].smp),
        .i_re      (en),
        .i_raddr_a (fb.a0),
        .i_raddr_b (fb.a1),
        .o_rdata_a (y0_b),
        .o_rdata_b (y1_b)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_a <= fa.t;
            r_t_b <= fb.t;
        end
    end

    // Stage 16: interpolation product (y1 - y0) * t. A zero weight leaves
    // the neighbor sample out, so only the sample at x0 matters.
    logic signed [SMP_W:0]       dy_a;
    logic signed [SMP_W:0]       dy_b;
    logic signed [2*SMP_W+1:0]   r_prod_a;
    logic signed [2*SMP_W+1:0]   r_prod_b;
    logic [SMP_W-1:0]            r_y0_a;
    logic [SMP_W-1:0]            r_y0_b;

    assign dy_a = $signed({1'b0, y1_a}) - $signed({1'b0, y0_a});
    assign dy_b = $signed({1'b0, y1_b}) - $signed({1'b0, y0_b});

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_t_a == '0) begin
                r_prod_a <= '0;
            end else begin
                r_prod_a <= dy_a * $signed({1'b0, r_t_a});
            end
            if (r_t_b == '0) begin
                r_prod_b <= '0;
            end else begin
                r_prod_b <= dy_b * $signed({1'b0, r_t_b});
            end
            r_y0_a   <= y0_a;
            r_y0_b   <= y0_b;
        end
    end

    // Stage 17: stretched samples y0 + floor(product / 2^16).
    logic signed [2*SMP_W+1:0] sa;
    logic signed [2*SMP_W+1:0] sb;
    logic [SMP_W-1:0]          r_va;
    logic [SMP_W-1:0]          r_vb;

    assign sa = $signed({18'b0, r_y0_a}) + (r_prod_a >>> FRAC_W);
    assign sb = $signed({18'b0, r_y0_b}) + (r_prod_b >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_va <= sa[SMP_W-1:0];
            r_vb <= sb[SMP_W-1:0];
        end
    end

    // Stage 18: blend product (vb - va) * f. A zero fraction returns shape A
    // alone, whatever shape B holds.
    logic signed [SMP_W:0]     dv;
    logic signed [2*SMP_W+1:0] r_bprod;
    logic [SMP_W-1:0]          r_va2;

    assign dv = $signed({1'b0, r_vb}) - $signed({1'b0, r_va});

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ctl[18].frac == '0) begin
                r_bprod <= '0;
            end else begin
                r_bprod <= dv * $signed({1'b0, r_ctl[18].frac});
            end
            r_va2   <= r_va;
        end
    end

    // Stage 19: final sample, forced to zero on a range error.
    logic signed [2*SMP_W+1:0] sv;
    logic [SMP_W-1:0]          r_out;

    assign sv = $signed({18'b0, r_va2}) + (r_bprod >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= r_ctl[19].err ? '0 : sv[SMP_W-1:0];
        end
    end

    // Control pipeline: input capture, then shifting; stage 3 also takes the section and limits from stage 2.
    always_comb begin
        n_ctl[0].vld   = i_req.valid;
        n_ctl[0].req   = i_req.req_type;
        n_ctl[0].idx   = i_req.shape_index;
        n_ctl[0].nxt   = (nxt_wide == cnt) ? '0 : nxt_wide[SHAPE_W-1:0];
        n_ctl[0].pos   = i_req.position;
        n_ctl[0].smp   = i_req.sample_value;
        n_ctl[0].pkv   = i_req.peak_value;
        n_ctl[0].frac  = i_req.blend_fraction;
        n_ctl[0].err   = {1'b0, i_req.shape_index} >= cnt;
        n_ctl[0].left  = 1'b0;
        n_ctl[0].lim_a = '0;
        n_ctl[0].lim_b = '0;
        for (int s = 1; s < NSTG; s++) begin
            n_ctl[s] = r_ctl[s-1];
        end
        n_ctl[3].left  = left;
        n_ctl[3].lim_a = lim_a;
        n_ctl[3].lim_b = lim_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_ctl[s].vld <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < NSTG; s++) begin
                r_ctl[s] <= n_ctl[s];
            end
        end
    end

    // Result register: only queries produce a transfer.
    assign o_res.valid          = r_ctl[NSTG-1].vld && (r_ctl[NSTG-1].req == REQ_QUERY);
    assign o_res.morphed_sample = r_out;
    assign o_res.out_position   = r_ctl[NSTG-1].pos;
    assign o_res.range_error    = r_ctl[NSTG-1].err;

endmodule

// File: hw/rtl/pem_ram.sv
// Simple RAM: one write port, two registered read ports.
module pem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: hw/rtl/pem_div.sv
// Pipelined restoring divider: q = (m << 32) / d, where the caller
// guarantees the quotient fits in G_W bits (m << 8 below d).
module pem_div import pem_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [M_W-1:0] i_m,
    input  logic [G_W-1:0] i_d,
    output logic [G_W-1:0] o_q
);

    logic [G_W-1:0] r_rem [DIV_STAGES];
    logic [G_W-1:0] r_quo [DIV_STAGES];
    logic [G_W-1:0] r_div [DIV_STAGES];
    logic [G_W-1:0] n_rem [DIV_STAGES];
    logic [G_W-1:0] n_quo [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [G_W-1:0] rem_in;
        logic [G_W-1:0] quo_in;
        logic [G_W-1:0] div_in;

        if (s == 0) begin : g_first
            assign rem_in = {i_m, (G_W-M_W)'(0)};
            assign quo_in = '0;
            assign div_in = i_d;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign div_in = r_div[s-1];
        end

        // Shift in a zero numerator bit, compare and subtract.
        always_comb begin
            logic [G_W:0] trial;
            n_rem[s] = rem_in;
            n_quo[s] = quo_in;
            for (int k = 0; k < DIV_BITS; k++) begin
                trial = {n_rem[s], 1'b0};
                if (trial >= {1'b0, div_in}) begin
                    n_rem[s] = G_W'(trial - {1'b0, div_in});
                    n_quo[s] = {n_quo[s][G_W-2:0], 1'b1};
                end else begin
                    n_rem[s] = trial[G_W-1:0];
                    n_quo[s] = {n_quo[s][G_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_div[s] <= div_in;
            end
        end
    end

    assign o_q = r_quo[DIV_STAGES-1];

endmodule

// File: tb/tb_top.sv
module tb_top;
    import pem_pkg::*;

    // The request code that the block leaves unused.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [SMP_W-1:0] morphed_sample;
        logic [POS_W-1:0] out_position;
        logic             range_error;
    } morph_result_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    pem_req_if req_ch ();
    pem_res_if res_ch ();

    peak_aligned_envelope_morph u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    // Shadow copy of the block state.
    logic [SMP_W-1:0] shadow_shapes [MAX_SHAPES*ENV_SIZE];
    logic [POS_W-1:0] shadow_peaks [MAX_SHAPES];
    logic [CNT_W-1:0] shadow_count;

    morph_result_t pending_results [$];
    int mismatches;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample of one shape, stretched so that its peak lands on the ghost peak.
    function automatic longint unsigned stretch_sample(int s, longint unsigned p,
                                                       longint unsigned g16);
        longint unsigned pk;
        longint unsigned gi;
        longint unsigned ox;
        longint unsigned x0;
        longint unsigned x1;
        longint unsigned t;
        longint unsigned span;
        longint unsigned q;
        longint unsigned d16;
        longint unsigned y0;
        longint unsigned y1;
        pk = shadow_peaks[s];
        if (pk > ENV_SIZE - 1) pk = ENV_SIZE - 1;
        gi = g16 >> 16;
        if (p <= gi) begin
            ox = (g16 == 0) ? 0 : (((p * pk) << 32) / g16);
            x0 = ox >> 16;
            t = ox & 64'hFFFF;
            if (x0 > pk) begin
                x0 = pk;
                t = 0;
            end
            x1 = (x0 + 1 > pk) ? pk : x0 + 1;
            y0 = shadow_shapes[s*ENV_SIZE + x0];
            y1 = shadow_shapes[s*ENV_SIZE + x1];
        end else begin
            span = ENV_SIZE - 1 - pk;
            q = ENV_SIZE - 1 - p;
            d16 = ((ENV_SIZE - 1) << 16) - g16;
            ox = (d16 == 0) ? 0 : (((q * span) << 32) / d16);
            x0 = ox >> 16;
            t = ox & 64'hFFFF;
            if (x0 > span) begin
                x0 = span;
                t = 0;
            end
            x1 = (x0 + 1 > span) ? span : x0 + 1;
            y0 = shadow_shapes[s*ENV_SIZE + ENV_SIZE - 1 - x0];
            y1 = shadow_shapes[s*ENV_SIZE + ENV_SIZE - 1 - x1];
        end
        return (y0 * (65536 - t) + y1 * t) >> 16;
    endfunction

    // Expected result of one query.
    function automatic morph_result_t morph_query(int a, int p, int f);
        morph_result_t r;
        int cnt;
        int b;
        longint pa;
        longint pb;
        longint g;
        longint unsigned va;
        longint unsigned vb;
        longint unsigned mix;
        cnt = (shadow_count > MAX_SHAPES) ? MAX_SHAPES : shadow_count;
        r.out_position = POS_W'(p);
        r.range_error = 1'b0;
        r.morphed_sample = '0;
        if (a >= cnt) begin
            r.range_error = 1'b1;
        end else if (p >= ENV_SIZE) begin
            r.morphed_sample = '0;
        end else if (f == 0) begin
            r.morphed_sample = shadow_shapes[a*ENV_SIZE + p];
        end else begin
            b = (a + 1) % cnt;
            pa = shadow_peaks[a];
            pb = shadow_peaks[b];
            if (pa > ENV_SIZE - 1) pa = ENV_SIZE - 1;
            if (pb > ENV_SIZE - 1) pb = ENV_SIZE - 1;
            g = pa * 65536 + (pb - pa) * f;
            if (g < 0) g = 0;
            va = stretch_sample(a, p, g);
            vb = stretch_sample(b, p, g);
            mix = ((65536 - f) * va + f * vb) >> 16;
            r.morphed_sample = mix[SMP_W-1:0];
        end
        return r;
    endfunction

    // Offer one item and hold it until the block takes it.
    task automatic send_item(logic [REQ_W-1:0] kind, int idx, int pos, int smp,
                             int pk, int f);
        int gap;
        req_ch.valid = 1'b1;
        req_ch.req_type = kind;
        req_ch.shape_index = SHAPE_W'(idx);
        req_ch.position = POS_W'(pos);
        req_ch.sample_value = SMP_W'(smp);
        req_ch.peak_value = POS_W'(pk);
        req_ch.blend_fraction = FRAC_W'(f);
        do @(posedge i_clk); while (!req_ch.ready);
        case (kind)
            REQ_WR_SAMPLE: shadow_shapes[idx*ENV_SIZE + pos] = SMP_W'(smp);
            REQ_WR_PEAK:   shadow_peaks[idx] = POS_W'(pk);
            REQ_QUERY:     pending_results.insert(pending_results.size(),
                                                  morph_query(idx, pos, f));
            default: ;
        endcase
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drop_valid();
        req_ch.valid = 1'b0;
    endtask

    // Wait until every query has come back and the pipeline has drained.
    task automatic wait_drained();
        drop_valid();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_shape_count(int value);
        wait_drained();
        i_cfg_we = 1'b1;
        i_cfg_wdata = CNT_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shadow_count = CNT_W'(value);
    endtask

    // Receiver: random stalls plus an optional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready = 1'b0;
        end else if (hold_off_cycles > 0) begin
            res_ch.ready = 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        morph_result_t want;
        morph_result_t got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.morphed_sample = res_ch.morphed_sample;
            got.out_position = res_ch.out_position;
            got.range_error = res_ch.range_error;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sample %h pos %0d err %0b",
                             got.morphed_sample, got.out_position, got.range_error);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %h/%0d/%0b got %h/%0d/%0b",
                                 want.morphed_sample, want.out_position,
                                 want.range_error, got.morphed_sample,
                                 got.out_position, got.range_error);
                end
            end
        end
    end

    // Fill every sample and peak so that no query reads an unwritten entry.
    task automatic test_table_fill();
        int v;
        set_shape_count(MAX_SHAPES);
        for (int s = 0; s < MAX_SHAPES; s++) begin
            for (int p = 0; p < ENV_SIZE; p++) begin
                v = (p == 0) ? 0 : (p == ENV_SIZE - 1) ? 16'hFFFF : $urandom_range(16'hFFFF);
                send_item(REQ_WR_SAMPLE, s, p, v, 0, 0);
            end
            send_item(REQ_WR_PEAK, s, 0, 0, $urandom_range(255), 0);
        end
    endtask

    // Extremes of every field and the named corner cases.
    task automatic test_directed();
        // Both peaks at zero: ghost peak zero.
        send_item(REQ_WR_PEAK, 0, 0, 0, 0, 0);
        send_item(REQ_WR_PEAK, 1, 0, 0, 0, 0);
        send_item(REQ_QUERY, 0, 0, 0, 0, 16'h8000);
        send_item(REQ_QUERY, 0, 255, 0, 0, 16'hFFFF);
        // Both peaks at the last sample: right section is empty.
        send_item(REQ_WR_PEAK, 2, 0, 0, 255, 0);
        send_item(REQ_WR_PEAK, 3, 0, 0, 255, 0);
        send_item(REQ_QUERY, 2, 255, 0, 0, 16'h0001);
        send_item(REQ_QUERY, 2, 128, 0, 0, 16'hFFFF);
        // Peaks moving in opposite directions, with the wrap to shape zero.
        send_item(REQ_WR_PEAK, 7, 0, 0, 255, 0);
        send_item(REQ_QUERY, 7, 100, 0, 0, 16'h4000);
        send_item(REQ_QUERY, 1, 200, 0, 0, 16'hC000);
        // Fraction zero returns the stored sample.
        send_item(REQ_WR_SAMPLE, 5, 17, 16'hFFFF, 0, 0);
        send_item(REQ_QUERY, 5, 17, 0, 0, 0);
        send_item(REQ_WR_SAMPLE, 5, 17, 16'h0000, 0, 0);
        send_item(REQ_QUERY, 5, 17, 0, 0, 0);
        // Unused request code gives nothing.
        send_item(REQ_UNUSED, 7, 255, 16'hFFFF, 255, 16'hFFFF);
        send_item(REQ_QUERY, 6, 0, 0, 0, 16'hFFFF);
        // Shape count of one: shape A wraps onto itself, others are errors.
        set_shape_count(1);
        send_item(REQ_QUERY, 0, 50, 0, 0, 16'h1234);
        send_item(REQ_QUERY, 1, 50, 0, 0, 16'h1234);
        send_item(REQ_QUERY, 7, 255, 0, 0, 0);
        // Zero shape count: every query is a range error.
        set_shape_count(0);
        send_item(REQ_QUERY, 0, 0, 0, 0, 0);
        send_item(REQ_QUERY, 0, 255, 0, 0, 16'hFFFF);
    endtask

    // Random mix of loads and queries.
    task automatic test_random_mix(int count);
        int r;
        int f;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 60) begin
                case ($urandom_range(9))
                    0, 1:    f = 0;
                    2:       f = 16'hFFFF;
                    3:       f = $urandom_range(15, 1);
                    default: f = $urandom_range(16'hFFFF);
                endcase
                send_item(REQ_QUERY, $urandom_range(7), $urandom_range(255), 0, 0, f);
            end else if (r < 88) begin
                send_item(REQ_WR_SAMPLE, $urandom_range(7), $urandom_range(255),
                          $urandom_range(16'hFFFF), 0, 0);
            end else if (r < 97) begin
                send_item(REQ_WR_PEAK, $urandom_range(7), 0, 0, $urandom_range(255), 0);
            end else begin
                send_item(REQ_UNUSED, $urandom_range(7), $urandom_range(255),
                          $urandom_range(16'hFFFF), $urandom_range(255),
                          $urandom_range(16'hFFFF));
            end
        end
    endtask

    // Long receiver hold-off while queries keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 300;
        for (int i = 0; i < 80; i++)
            send_item(REQ_QUERY, $urandom_range(7), $urandom_range(255), 0, 0,
                      $urandom_range(16'hFFFF));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_WR_SAMPLE;
        req_ch.shape_index = '0;
        req_ch.position = '0;
        req_ch.sample_value = '0;
        req_ch.peak_value = '0;
        req_ch.blend_fraction = '0;
        res_ch.ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        shadow_count = 1;
        for (int s = 0; s < MAX_SHAPES; s++) shadow_peaks[s] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_table_fill();
        test_directed();

        set_shape_count(MAX_SHAPES);
        test_random_mix(450);

        send_idle_pct = 45;
        set_shape_count(15);
        test_random_mix(450);

        send_idle_pct = 0;
        recv_stall_pct = 45;
        set_shape_count(3);
        test_random_mix(450);

        send_idle_pct = 25;
        recv_stall_pct = 25;
        set_shape_count(2);
        test_random_mix(450);

        set_shape_count(MAX_SHAPES);
        test_backpressure();

        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/pem_pkg.sv
hw/rtl/pem_if.sv
hw/rtl/pem_ram.sv
hw/rtl/pem_div.sv
hw/rtl/peak_aligned_envelope_morph.sv
tb/tb_top.sv
